// ===== rtl/core/xlsu_pkg.sv =====
// ----------------------------------------------------------------------------
// xlsu_pkg
// Shared types and codes for the x86 logic and shift unit.
// ----------------------------------------------------------------------------
package xlsu_pkg;

    // operation codes (req_type)
    localparam logic [3:0] OP_TEST  = 4'd0;
    localparam logic [3:0] OP_AND   = 4'd1;
    localparam logic [3:0] OP_XOR   = 4'd2;
    localparam logic [3:0] OP_OR    = 4'd3;
    localparam logic [3:0] OP_SAR   = 4'd4;
    localparam logic [3:0] OP_SHL   = 4'd5;
    localparam logic [3:0] OP_SHR   = 4'd6;
    localparam logic [3:0] OP_ROL   = 4'd7;
    localparam logic [3:0] OP_SETCC = 4'd8;
    localparam logic [3:0] OP_NOT   = 4'd9;

    // operand size codes
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;

    // flag bit positions
    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_ZF = 1;
    localparam int unsigned FLAG_SF = 2;
    localparam int unsigned FLAG_OF = 3;

    // condition groups (condition code without its negate bit)
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_E  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [1:0]  operand_size;
        logic [31:0] dest_value;
        logic [31:0] src_value;
        logic [3:0]  cond_code;
    } t_req;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_dest;
        logic [3:0]  flags_out;
    } t_rsp;

endpackage

// ===== rtl/core/x86_logic_shift_unit.sv =====
// ----------------------------------------------------------------------------
// x86_logic_shift_unit
// Logic, shift, rotate and setcc execute unit with kept x86 flags.
// ----------------------------------------------------------------------------
// usage
//   request channel: i_req_valid / o_req_ready carry one instruction per
//   transaction (operation, operand size, destination, source or count, cc)
//   response channel: o_rsp_valid / i_rsp_ready carry the result, the write
//   enable and the flags as they stand after that instruction
//   path: a request is taken into the input register and moves on into the
//   result register, where its response is valid, once that register is
//   empty or its response is being taken
//   throughput: one transaction per cycle while responses are taken; the
//   execute logic sits between the input and result registers, and the
//   flag register is written when an instruction moves into the result
//   register, so setcc of the next instruction already sees those flags
//   stall: while a response waits, one more request is held in the input
//   register; request ready drops only when both registers are full
//   reset: synchronous, active low; both stages empty, all flags zero
// ----------------------------------------------------------------------------
module x86_logic_shift_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  xlsu_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output xlsu_pkg::t_rsp o_rsp
);

    // input stage
    xlsu_pkg::t_req r_req;
    logic           r_req_valid;
    // result stage
    xlsu_pkg::t_rsp r_rsp;
    logic           r_rsp_valid;
    // kept flags: CF, ZF, SF, OF
    logic [3:0]     r_flags;

    xlsu_pkg::t_rsp n_rsp;
    logic           req_fire;
    logic           advance;

    // move the input stage on when the result stage is empty or being taken
    assign advance     = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || advance;
    assign req_fire    = i_req_valid && o_req_ready;

    xlsu_exec u_exec (
        .i_req   (r_req),
        .i_flags (r_flags),
        .o_rsp   (n_rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (req_fire) begin
                r_req_valid <= 1'b1;
            end else if (advance) begin
                r_req_valid <= 1'b0;
            end
            if (advance) begin
                r_rsp_valid <= 1'b1;
                r_flags     <= n_rsp.flags_out;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/core/xlsu_exec.sv =====
// ----------------------------------------------------------------------------
// xlsu_exec
// Combinational execute logic: result, write enable and next flags.
// ----------------------------------------------------------------------------
module xlsu_exec (
    input  xlsu_pkg::t_req i_req,
    input  logic [3:0]     i_flags,
    output xlsu_pkg::t_rsp o_rsp
);

    logic [5:0]  w;
    logic [31:0] m;
    logic [31:0] d;
    logic [31:0] s;
    logic [4:0]  sh_n;
    logic [4:0]  rot_n;
    logic [31:0] sx;
    logic [31:0] r;
    logic        wr;
    logic [3:0]  nf;
    logic        sign_d;
    logic        cond_v;
    logic        cf;
    logic        zf;
    logic        sf;
    logic        of;

    // zero and sign of a result at operand width
    function automatic logic [3:0] zf_sf(input logic [31:0] v, input logic [1:0] size);
        logic [3:0] f;
        f = '0;
        f[xlsu_pkg::FLAG_ZF] = (v == 32'd0);
        case (size)
            xlsu_pkg::SIZE_BYTE: f[xlsu_pkg::FLAG_SF] = v[7];
            xlsu_pkg::SIZE_WORD: f[xlsu_pkg::FLAG_SF] = v[15];
            default:             f[xlsu_pkg::FLAG_SF] = v[31];
        endcase
        return f;
    endfunction

    always_comb begin
        case (i_req.operand_size)
            xlsu_pkg::SIZE_BYTE: begin
                w      = 6'd8;
                m      = 32'h0000_00ff;
                sign_d = i_req.dest_value[7];
            end
            xlsu_pkg::SIZE_WORD: begin
                w      = 6'd16;
                m      = 32'h0000_ffff;
                sign_d = i_req.dest_value[15];
            end
            default: begin
                w      = 6'd32;
                m      = 32'hffff_ffff;
                sign_d = i_req.dest_value[31];
            end
        endcase
    end

    assign d     = i_req.dest_value & m;
    assign s     = i_req.src_value & m;
    assign sh_n  = i_req.src_value[4:0];
    // width is a power of two, so the modulo is a mask
    assign rot_n = i_req.src_value[4:0] & (w[4:0] - 5'd1);
    assign sx    = d | (sign_d ? ~m : 32'd0);

    assign cf = i_flags[xlsu_pkg::FLAG_CF];
    assign zf = i_flags[xlsu_pkg::FLAG_ZF];
    assign sf = i_flags[xlsu_pkg::FLAG_SF];
    assign of = i_flags[xlsu_pkg::FLAG_OF];

    always_comb begin
        case (i_req.cond_code[3:1])
            xlsu_pkg::CC_O:  cond_v = of;
            xlsu_pkg::CC_B:  cond_v = cf;
            xlsu_pkg::CC_E:  cond_v = zf;
            xlsu_pkg::CC_BE: cond_v = cf | zf;
            xlsu_pkg::CC_S:  cond_v = sf;
            xlsu_pkg::CC_L:  cond_v = sf ^ of;
            xlsu_pkg::CC_LE: cond_v = zf | (sf ^ of);
            default:         cond_v = 1'b0;
        endcase
        // parity conditions are false in both senses
        if (i_req.cond_code[3:1] != xlsu_pkg::CC_P) begin
            cond_v = cond_v ^ i_req.cond_code[0];
        end
    end

    always_comb begin
        r  = d;
        wr = 1'b1;
        nf = i_flags;
        unique case (i_req.req_type) inside
            xlsu_pkg::OP_TEST: begin
                r  = d & s;
                wr = 1'b0;
                nf = zf_sf(r, i_req.operand_size);
            end
            xlsu_pkg::OP_AND: begin
                r  = d & s;
                nf = zf_sf(r, i_req.operand_size);
            end
            xlsu_pkg::OP_XOR: begin
                r  = d ^ s;
                nf = zf_sf(r, i_req.operand_size);
            end
            xlsu_pkg::OP_OR: begin
                r  = d | s;
                nf = zf_sf(r, i_req.operand_size);
            end
            xlsu_pkg::OP_SAR, xlsu_pkg::OP_SHL, xlsu_pkg::OP_SHR: begin
                if (i_req.req_type == xlsu_pkg::OP_SAR) begin
                    r = 32'($signed(sx) >>> sh_n) & m;
                end else if (i_req.req_type == xlsu_pkg::OP_SHL) begin
                    r = (d << sh_n) & m;
                end else begin
                    r = d >> sh_n;
                end
                // carry and overflow kept
                nf = zf_sf(r, i_req.operand_size);
                nf[xlsu_pkg::FLAG_CF] = cf;
                nf[xlsu_pkg::FLAG_OF] = of;
            end
            xlsu_pkg::OP_ROL: begin
                if (rot_n != 5'd0) begin
                    r = ((d << rot_n) | (d >> (w - {1'b0, rot_n}))) & m;
                    nf[xlsu_pkg::FLAG_CF] = r[0];
                end
            end
            xlsu_pkg::OP_SETCC: begin
                r = {31'd0, cond_v};
            end
            xlsu_pkg::OP_NOT: begin
                r = ~d & m;
            end
            default: begin
                wr = 1'b0;
            end
        endcase
    end

    assign o_rsp.result_value = r;
    assign o_rsp.write_dest   = wr;
    assign o_rsp.flags_out    = nf;

endmodule

// ===== rtl/core/xlsu_checker.sv =====
// ----------------------------------------------------------------------------
// xlsu_checker
// Port-level checks for the x86 logic and shift unit, bound to the top level.
// ----------------------------------------------------------------------------
module xlsu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_req_ready,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input xlsu_pkg::t_rsp o_rsp
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    // a stalled response stays up and unchanged
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response dropped or changed");

    // requests are held off only by a stalled response
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |-> o_rsp_valid && !i_rsp_ready)
        else $error("request ready low without a stalled response");

    // ready low after a response-ready cycle: no response then, or one up now
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready && $past(i_rsp_ready) |-> $past(!o_rsp_valid) || o_rsp_valid)
        else $error("request ready low after drain");

endmodule

bind x86_logic_shift_unit xlsu_checker u_checker (.*);

// ===== bench/tb_x86_logic_shift_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_x86_logic_shift_unit
// Self-checking bench for the logic and shift execute unit: a directed
// table of corner instructions, then random instruction streams under three
// idle mixes, each response checked field by field against its typed-in
// expectation or a local instruction model that tracks the kept flags.
// ----------------------------------------------------------------------------
module tb_x86_logic_shift_unit;
    import xlsu_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] SIZE_DWORD  = 2'd2;
    localparam logic [1:0] SIZE_ALIAS  = 2'd3;    // spare size code, runs as dword
    localparam logic [3:0] OP_RESERVED = 4'd15;   // spare operation code

    // flag masks for the typed-in expectations
    localparam logic [3:0] F_NONE = 4'd0;
    localparam logic [3:0] F_ZF   = 4'd1 << FLAG_ZF;
    localparam logic [3:0] F_SF   = 4'd1 << FLAG_SF;

    // two register stages between request and response
    localparam int RSP_LATENCY = 2;

    // one directed row: the instruction and, where obvious, its response
    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp rsp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    // model state: flags as the unit should hold them after every
    // instruction accepted so far
    logic [3:0] model_flags;

    // responses still owed by the unit, oldest first
    t_rsp       owed_rsp_q[$];
    t_dir_row   corner_rows[$];

    int send_idle_pct;
    int rsp_idle_pct;
    int n_sent;
    int n_checked;
    int n_errors;

    x86_logic_shift_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // instruction model
    // ------------------------------------------------------------------

    // zf and sf of a result at operand width
    function automatic logic [3:0] zero_sign(logic [31:0] r, int unsigned w);
        logic [3:0] f;
        f          = '0;
        f[FLAG_ZF] = (r == 32'd0);
        f[FLAG_SF] = r[w-1];
        return f;
    endfunction

    // x86 condition from the kept flags; the parity pair always reads 0
    function automatic logic cond_holds(logic [3:0] cc, logic [3:0] fl);
        logic v;
        case (cc[3:1])
            CC_O:    v = fl[FLAG_OF];
            CC_B:    v = fl[FLAG_CF];
            CC_E:    v = fl[FLAG_ZF];
            CC_BE:   v = fl[FLAG_CF] | fl[FLAG_ZF];
            CC_S:    v = fl[FLAG_SF];
            CC_P:    return 1'b0;
            CC_L:    v = fl[FLAG_SF] ^ fl[FLAG_OF];
            default: v = fl[FLAG_ZF] | (fl[FLAG_SF] ^ fl[FLAG_OF]);
        endcase
        return v ^ cc[0];
    endfunction

    // executes one instruction on the model flags and returns its response
    function automatic t_rsp execute_insn(t_req rq);
        int unsigned w;
        int unsigned n;
        logic [31:0] m;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] sx;
        logic [31:0] r;
        logic [3:0]  carry_ovf;
        t_rsp        rsp;
        case (rq.operand_size)
            SIZE_BYTE: w = 8;
            SIZE_WORD: w = 16;
            default:   w = 32;
        endcase
        m = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        d = rq.dest_value & m;
        s = rq.src_value & m;
        // shifts take the count's low five bits, unmasked by width
        n = 32'(rq.src_value[4:0]);
        carry_ovf = model_flags & ((4'd1 << FLAG_CF) | (4'd1 << FLAG_OF));
        r = d;
        rsp.write_dest = 1'b1;
        case (rq.req_type)
            OP_TEST: begin
                r = d & s;
                rsp.write_dest = 1'b0;
                model_flags = zero_sign(r, w);
            end
            OP_AND: begin
                r = d & s;
                model_flags = zero_sign(r, w);
            end
            OP_XOR: begin
                r = d ^ s;
                model_flags = zero_sign(r, w);
            end
            OP_OR: begin
                r = d | s;
                model_flags = zero_sign(r, w);
            end
            OP_SAR: begin
                sx = d;
                if (w < 32 && d[w-1]) begin
                    sx = d | ~m;
                end
                // keep the shift in its own statement so it stays arithmetic
                r = $signed(sx) >>> n;
                r = r & m;
                model_flags = carry_ovf | zero_sign(r, w);
            end
            OP_SHL: begin
                r = (d << n) & m;
                model_flags = carry_ovf | zero_sign(r, w);
            end
            OP_SHR: begin
                r = d >> n;
                model_flags = carry_ovf | zero_sign(r, w);
            end
            OP_ROL: begin
                // count modulo width; a zero count leaves dest and flags alone
                n = rq.src_value % w;
                if (n != 0) begin
                    r = ((d << n) | (d >> (w - n))) & m;
                    model_flags[FLAG_CF] = r[0];
                end
            end
            OP_SETCC: r = {31'd0, cond_holds(rq.cond_code, model_flags)};
            OP_NOT:   r = ~d & m;
            default:  rsp.write_dest = 1'b0;
        endcase
        rsp.result_value = r;
        rsp.flags_out    = model_flags;
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_error(string msg);
        n_errors++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic add_row(logic [3:0] op, logic [1:0] size, logic [31:0] dest,
                           logic [31:0] src, logic [3:0] cc,
                           logic typed = 1'b0, t_rsp rsp = '0);
        t_dir_row row;
        row.req   = '{req_type: op, operand_size: size, dest_value: dest,
                      src_value: src, cond_code: cc};
        row.typed = typed;
        row.rsp   = rsp;
        corner_rows.push_back(row);
    endtask

    // operands biased to zero, all ones, one set or one clear bit, small values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1 << $urandom_range(31);
            3:       return ~(32'd1 << $urandom_range(31));
            4:       return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_insn();
        t_req rq;
        // spare operation codes now and then, the ten real ones otherwise
        if ($urandom_range(49) == 0) begin
            rq.req_type = 4'($urandom_range(15, 10));
        end else begin
            rq.req_type = 4'($urandom_range(9));
        end
        if ($urandom_range(19) == 0) begin
            rq.operand_size = SIZE_ALIAS;
        end else begin
            rq.operand_size = 2'($urandom_range(2));
        end
        rq.dest_value = pick_operand();
        rq.src_value  = pick_operand();
        // shift and rotate counts half the time from 0 to 40, across the widths
        if (rq.req_type >= OP_SAR && rq.req_type <= OP_ROL && $urandom_range(1)) begin
            rq.src_value = 32'($urandom_range(40));
        end
        rq.cond_code = 4'($urandom_range(15));
        return rq;
    endfunction

    // one request transaction, with a random idle gap ahead of it; the
    // owed response is recorded at the edge that takes the request
    task automatic send_insn(t_req rq, logic typed = 1'b0, t_rsp typed_rsp = '0);
        t_rsp predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_req_valid <= 1'b1;
        i_req       <= rq;
        do @(posedge i_clk); while (!o_req_ready);
        // the model runs on typed rows too, so the flags stay in step
        predicted = execute_insn(rq);
        owed_rsp_q.push_back(typed ? typed_rsp : predicted);
        n_sent++;
    endtask

    // hold off requests until every owed response has come back
    task automatic drain_unit();
        i_req_valid <= 1'b0;
        while (owed_rsp_q.size() != 0) @(posedge i_clk);
        repeat (RSP_LATENCY + 2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // response side: check each transaction, then pick the next ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (owed_rsp_q.size() == 0) begin
                report_error($sformatf("response with nothing owed: %h", o_rsp));
            end else begin
                want = owed_rsp_q.pop_front();
                if (o_rsp.result_value !== want.result_value) begin
                    report_error($sformatf("rsp %0d result_value %h, want %h",
                                           n_checked, o_rsp.result_value,
                                           want.result_value));
                end
                if (o_rsp.write_dest !== want.write_dest) begin
                    report_error($sformatf("rsp %0d write_dest %b, want %b",
                                           n_checked, o_rsp.write_dest,
                                           want.write_dest));
                end
                if (o_rsp.flags_out !== want.flags_out) begin
                    report_error($sformatf("rsp %0d flags_out %b, want %b",
                                           n_checked, o_rsp.flags_out,
                                           want.flags_out));
                end
                n_checked++;
            end
        end
        i_rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        model_flags   = '0;
        send_idle_pct = 27;
        rsp_idle_pct  = 84;
        n_sent        = 0;
        n_checked     = 0;
        n_errors      = 0;

        // corner table; flags start clear after reset
        // setcc straight out of reset: overflow clear
        add_row(OP_SETCC, SIZE_BYTE, 32'h0, 32'h0, {CC_O, 1'b0}, 1'b1,
                '{32'h0, 1'b1, F_NONE});
        add_row(OP_SETCC, SIZE_BYTE, 32'h0, 32'h0, {CC_O, 1'b1}, 1'b1,
                '{32'h1, 1'b1, F_NONE});
        // test sets zf, writes nothing
        add_row(OP_TEST, SIZE_BYTE, 32'hFF, 32'h00, 4'h0, 1'b1,
                '{32'h0, 1'b0, F_ZF});
        add_row(OP_SETCC, SIZE_BYTE, 32'h0, 32'h0, {CC_E, 1'b0}, 1'b1,
                '{32'h1, 1'b1, F_ZF});
        add_row(OP_AND, SIZE_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 1'b1,
                '{32'hFFFF_FFFF, 1'b1, F_SF});
        // bits above the operand width are dropped
        add_row(OP_XOR, SIZE_WORD, 32'hABCD_1234, 32'h1234_FFFF, 4'h0);
        add_row(OP_OR, SIZE_BYTE, 32'hFFFF_FF00, 32'h0000_0100, 4'h0, 1'b1,
                '{32'h0, 1'b1, F_ZF});
        // parity conditions read 0 either way
        add_row(OP_SETCC, SIZE_BYTE, 32'h0, 32'h0, {CC_P, 1'b0}, 1'b1,
                '{32'h0, 1'b1, F_ZF});
        add_row(OP_SETCC, SIZE_BYTE, 32'h0, 32'h0, {CC_P, 1'b1}, 1'b1,
                '{32'h0, 1'b1, F_ZF});
        add_row(OP_NOT, SIZE_BYTE, 32'h0F, 32'h0, 4'h0);
        add_row(OP_NOT, SIZE_DWORD, 32'h0, 32'hFFFF_FFFF, 4'h0);
        // rotate sets carry, then setcc below reads it
        add_row(OP_ROL, SIZE_BYTE, 32'h81, 32'h1, 4'h0);
        add_row(OP_SETCC, SIZE_WORD, 32'h0, 32'h0, {CC_B, 1'b0});
        // rotate by the full width changes nothing, all ones rotates by 31
        add_row(OP_ROL, SIZE_BYTE, 32'h5A, 32'h8, 4'h0);
        add_row(OP_ROL, SIZE_DWORD, 32'h8000_0001, 32'hFFFF_FFFF, 4'h0);
        // sar sign-extends from the operand width
        add_row(OP_SAR, SIZE_BYTE, 32'h80, 32'h7, 4'h0);
        add_row(OP_SAR, SIZE_WORD, 32'h8000, 32'h21, 4'h0);
        add_row(OP_SAR, SIZE_DWORD, 32'h8000_0000, 32'h1F, 4'h0);
        // zero shift count still updates zf and sf
        add_row(OP_SAR, SIZE_BYTE, 32'h0, 32'h0, 4'h0);
        add_row(OP_SHL, SIZE_DWORD, 32'h1, 32'h1F, 4'h0);
        add_row(OP_SHL, SIZE_BYTE, 32'hFF, 32'hFFFF_FFE0, 4'h0);
        add_row(OP_SHR, SIZE_WORD, 32'hFFFF, 32'h1F, 4'h0);
        // spare size code runs as doubleword
        add_row(OP_AND, SIZE_ALIAS, 32'hF0F0_F0F0, 32'hFFFF_0000, 4'h0);
        // spare operation: masked dest, no write, flags kept
        add_row(OP_RESERVED, SIZE_BYTE, 32'h1234, 32'h0, 4'h0);
        add_row(OP_SETCC, SIZE_DWORD, 32'h0, 32'h0, {CC_LE, 1'b1});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: busy sender, slow receiver (pressure on the stall path)
        foreach (corner_rows[k]) begin
            send_insn(corner_rows[k].req, corner_rows[k].typed, corner_rows[k].rsp);
        end
        repeat (400) send_insn(random_insn());
        drain_unit();

        // phase 2: sparse sender, mostly ready receiver
        send_idle_pct = 84;
        rsp_idle_pct  = 27;
        repeat (420) send_insn(random_insn());
        drain_unit();

        // phase 3: back to back, no idling on either side
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        repeat (420) send_insn(random_insn());
        drain_unit();

        $display("covered %0d instructions, %0d responses checked: all ten operations,",
                 n_sent, n_checked);
        $display("three operand sizes plus the spare code, under three idle mixes");
        if (n_errors == 0) begin
            $display("x86_logic_shift_unit verification clean");
        end else begin
            $display("%0d errors", n_errors);
            $display("x86_logic_shift_unit verification failed");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("timeout, %0d responses still owed", owed_rsp_q.size());
        $display("x86_logic_shift_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/xlsu_pkg.sv
rtl/core/xlsu_exec.sv
rtl/core/x86_logic_shift_unit.sv
rtl/core/xlsu_checker.sv
bench/tb_x86_logic_shift_unit.sv
